@@ rtl/core/bcsm_pkg.sv @@
package bcsm_pkg;

  // Sizing of the point store.
  localparam int Points    = 256;
  localparam int PosW      = $clog2(Points);
  localparam int CntW      = PosW + 1;

  // Calibration
  localparam int CalFrames = 50;
  localparam int CalHalf   = CalFrames / 2;
  localparam int FrmW      = 6;
  localparam int SumW      = 22;

  // Sample and level ranges
  localparam int RawW      = 16;
  localparam int LvlW      = 10;
  localparam int PcW       = 9;
  localparam int ProdW     = RawW + LvlW;
  localparam logic [RawW-1:0] RawMax    = 16'hFFFF;
  localparam logic [LvlW-1:0] LevelSpan = 10'd1018;
  localparam logic [LvlW:0]   LevelMax  = 11'd1019;

  // Serial divider step counts
  localparam int StepW     = 5;
  localparam logic [StepW-1:0] BaseSteps = StepW'(RawW);
  localparam logic [StepW-1:0] LvlSteps  = StepW'(LvlW);

  // Load request for the shared serial divider.
  typedef struct packed {
    logic              start;
    logic [RawW-1:0]   rem;
    logic [RawW-1:0]   low;
    logic [RawW-1:0]   divisor;
    logic [StepW-1:0]  steps;
  } div_req_t;

  // Frame length actually used: zero counts as one, clamp to the store size.
  function automatic logic [CntW-1:0] active_points(input logic [PcW-1:0] pc);
    logic [CntW-1:0] n;
    if (pc == '0) begin
      n = CntW'(1);
    end else if (int'(pc) > Points) begin
      n = CntW'(Points);
    end else begin
      n = CntW'(pc);
    end
    return n;
  endfunction

endpackage

@@ rtl/core/baseline_calibrated_sample_mapper.sv @@
// Per-point baseline subtraction with a deadband for a sensor matrix. Samples
// arrive in frame order and the block keeps the point position itself. For
// the first 50 frames every sample is summed per point (written on the first
// frame) and the result level is 0 with calibrating set. Afterwards each
// point's baseline is the rounded average of its sum, computed per sample by
// a bit-serial divider straight from the stored sum, so no sweep over the
// store is needed when calibration ends. The threshold is baseline plus
// deadband, capped at 65535; samples at or below it give 0, otherwise the
// level is 1 + (sample - threshold) * 1018 / (65535 - threshold), capped at
// 1019. A restart item (kind = 1) or a write to the frame length register
// restarts calibration; a restart item yields no result. A calibration sample
// passes through the read and output states before it sits in the output
// register, and the next item can transfer once the block is idle again. A
// mapped sample runs through the shared radix-2 divider twice (16 steps for
// the baseline, 10 for the level) before its result is registered; a sample
// that falls in the deadband skips the level divide. A restart item leaves
// the block idle. A finished result waits in the output register, and the
// next item is taken while it waits; that item then holds at its last step
// until the output register is free. The sum store powers up undefined and
// needs no clearing: the first calibration frame writes every point in use
// before its stored sum is used. Registers: frame length (points per frame)
// at byte address 0, deadband at byte address 4.
module baseline_calibrated_sample_mapper
  import bcsm_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  // configuration
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready,
  // input channel
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            in_kind,
  input  logic [15:0]     in_sample,
  // result channel
  output logic            out_valid,
  input  logic            out_ready,
  output logic [9:0]      out_level,
  output logic            out_calibrating,
  output logic [5:0]      out_frames_done,
  output logic [7:0]      out_point_position,
  output logic            out_frame_end
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_BASE = 3'd2;
  localparam logic [2:0] S_THR  = 3'd3;
  localparam logic [2:0] S_LVL  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  localparam logic RegFrameLen = 1'b0;
  localparam logic RegDeadband = 1'b1;

  logic [2:0]       state_r, state_nxt;

  // configuration registers
  logic [PcW-1:0]   frame_len_r, frame_len_nxt;
  logic [RawW-1:0]  deadband_r, deadband_nxt;

  // calibration state
  logic [FrmW-1:0]  frame_r, frame_nxt;
  logic             calibrated_r, calibrated_nxt;
  logic [PosW-1:0]  pos_r, pos_nxt;

  // item being worked on
  logic [RawW-1:0]  raw_r, raw_nxt;
  logic [PosW-1:0]  item_pos_r, item_pos_nxt;
  logic             item_last_r, item_last_nxt;
  logic             item_cal_r, item_cal_nxt;
  logic [RawW-1:0]  thr_r, thr_nxt;
  logic [LvlW-1:0]  res_level_r, res_level_nxt;
  logic [FrmW-1:0]  res_frames_r, res_frames_nxt;

  // output register
  logic             out_valid_r, out_valid_nxt;
  logic [LvlW-1:0]  out_level_r, out_level_nxt;
  logic             out_cal_r, out_cal_nxt;
  logic [FrmW-1:0]  out_frames_r, out_frames_nxt;
  logic [PosW-1:0]  out_pos_r, out_pos_nxt;
  logic             out_last_r, out_last_nxt;

  logic             cfg_wr;
  logic             in_xfer;
  logic [CntW-1:0]  n_eff;
  logic [PosW-1:0]  pos_cur;
  logic             last_cur;

  logic             mem_wr_en;
  logic [SumW-1:0]  mem_wr_data;
  logic             mem_rd_en;
  logic [SumW-1:0]  mem_rd_data;
  logic [SumW:0]    sum_rnd;
  logic [SumW-1:0]  sum_acc;

  div_req_t         div_req;
  logic             div_done;
  logic [RawW-1:0]  div_quot;

  logic [RawW:0]    thr_sum;
  logic [RawW-1:0]  diff;
  logic [ProdW-1:0] prod;
  logic [LvlW:0]    lvl_inc;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    unique case (paddr[2])
      RegFrameLen: prdata = {{(32-PcW){1'b0}}, frame_len_r};
      RegDeadband: prdata = {{(32-RawW){1'b0}}, deadband_r};
      default:     prdata = '0;
    endcase
  end

  // Position of the incoming sample and end-of-frame detection.
  assign n_eff    = active_points(frame_len_r);
  assign pos_cur  = ({1'b0, pos_r} >= n_eff) ? '0 : pos_r;
  assign last_cur = (({1'b0, pos_cur} + CntW'(1)) >= n_eff);

  // Sum update and rounded baseline dividend.
  assign sum_acc = SumW'({1'b0, mem_rd_data} + (SumW+1)'(raw_r));
  assign sum_rnd = {1'b0, mem_rd_data} + (SumW+1)'(CalHalf);

  assign thr_sum = {1'b0, div_quot} + {1'b0, deadband_r};
  assign diff    = raw_r - thr_r;
  assign prod    = ProdW'(diff) * ProdW'(LevelSpan);
  assign lvl_inc = {1'b0, div_quot[LvlW-1:0]} + (LvlW+1)'(1);

  always_comb begin
    state_nxt       = state_r;
    frame_len_nxt   = frame_len_r;
    deadband_nxt    = deadband_r;
    frame_nxt       = frame_r;
    calibrated_nxt  = calibrated_r;
    pos_nxt         = pos_r;
    raw_nxt         = raw_r;
    item_pos_nxt    = item_pos_r;
    item_last_nxt   = item_last_r;
    item_cal_nxt    = item_cal_r;
    thr_nxt         = thr_r;
    res_level_nxt   = res_level_r;
    res_frames_nxt  = res_frames_r;
    out_valid_nxt   = out_valid_r;
    out_level_nxt   = out_level_r;
    out_cal_nxt     = out_cal_r;
    out_frames_nxt  = out_frames_r;
    out_pos_nxt     = out_pos_r;
    out_last_nxt    = out_last_r;
    mem_wr_en       = 1'b0;
    mem_wr_data     = sum_acc;
    mem_rd_en       = 1'b0;
    div_req         = '0;

    // Drop the output once the consumer takes it.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // Configuration writes must arrive only while idle; the block does not enforce it.
    if (cfg_wr) begin
      unique case (paddr[2])
        RegFrameLen: begin
          frame_len_nxt   = pwdata[PcW-1:0];
          frame_nxt       = '0;
          calibrated_nxt  = 1'b0;
          pos_nxt         = '0;
        end
        RegDeadband: begin
          deadband_nxt = pwdata[RawW-1:0];
        end
        default: begin
          deadband_nxt = deadband_r;
        end
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_kind) begin
            // Restart: clear calibration progress, no result.
            frame_nxt      = '0;
            calibrated_nxt = 1'b0;
            pos_nxt        = '0;
          end else begin
            raw_nxt       = in_sample;
            item_pos_nxt  = pos_cur;
            item_last_nxt = last_cur;
            item_cal_nxt  = !calibrated_r;
            pos_nxt       = last_cur ? '0 : pos_cur + PosW'(1);
            mem_rd_en     = 1'b1;
            state_nxt     = S_READ;
          end
        end
      end
      S_READ: begin
        if (item_cal_r) begin
          // Accumulate: write the raw value on the first frame.
          mem_wr_en     = 1'b1;
          mem_wr_data   = (frame_r == '0) ? SumW'(raw_r) : sum_acc;
          res_level_nxt = '0;
          if (item_last_r) begin
            frame_nxt      = frame_r + FrmW'(1);
            res_frames_nxt = frame_r + FrmW'(1);
            if ((frame_r + FrmW'(1)) >= FrmW'(CalFrames)) begin
              calibrated_nxt = 1'b1;
            end
          end else begin
            res_frames_nxt = frame_r;
          end
          state_nxt = S_OUT;
        end else begin
          // Baseline = (sum + half) / frames, quotient fits the raw width.
          res_frames_nxt  = frame_r;
          div_req.start   = 1'b1;
          div_req.rem     = RawW'(sum_rnd[SumW:RawW]);
          div_req.low     = sum_rnd[RawW-1:0];
          div_req.divisor = RawW'(CalFrames);
          div_req.steps   = BaseSteps;
          state_nxt       = S_BASE;
        end
      end
      S_BASE: begin
        if (div_done) begin
          thr_nxt   = thr_sum[RawW] ? RawMax : thr_sum[RawW-1:0];
          state_nxt = S_THR;
        end
      end
      S_THR: begin
        if ((raw_r <= thr_r) || (thr_r == RawMax)) begin
          res_level_nxt = '0;
          state_nxt     = S_OUT;
        end else begin
          // Quotient is at most the span, so only the low level bits are developed.
          div_req.start   = 1'b1;
          div_req.rem     = prod[ProdW-1:LvlW];
          div_req.low     = {prod[LvlW-1:0], {(RawW-LvlW){1'b0}}};
          div_req.divisor = RawMax - thr_r;
          div_req.steps   = LvlSteps;
          state_nxt       = S_LVL;
        end
      end
      S_LVL: begin
        if (div_done) begin
          res_level_nxt = (lvl_inc > LevelMax) ? LvlW'(LevelMax) : lvl_inc[LvlW-1:0];
          state_nxt     = S_OUT;
        end
      end
      S_OUT: begin
        // Hold until the output register is free.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_level_nxt  = res_level_r;
          out_cal_nxt    = item_cal_r;
          out_frames_nxt = res_frames_r;
          out_pos_nxt    = item_pos_r;
          out_last_nxt   = item_last_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      frame_len_r   <= PcW'(Points);
      deadband_r    <= RawW'(50);
      frame_r       <= '0;
      calibrated_r  <= 1'b0;
      pos_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      frame_len_r   <= frame_len_nxt;
      deadband_r    <= deadband_nxt;
      frame_r       <= frame_nxt;
      calibrated_r  <= calibrated_nxt;
      pos_r         <= pos_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    raw_r        <= raw_nxt;
    item_pos_r   <= item_pos_nxt;
    item_last_r  <= item_last_nxt;
    item_cal_r   <= item_cal_nxt;
    thr_r        <= thr_nxt;
    res_level_r  <= res_level_nxt;
    res_frames_r <= res_frames_nxt;
    out_level_r  <= out_level_nxt;
    out_cal_r    <= out_cal_nxt;
    out_frames_r <= out_frames_nxt;
    out_pos_r    <= out_pos_nxt;
    out_last_r   <= out_last_nxt;
  end

  bcsm_sum_mem u_sum_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (item_pos_r),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (pos_cur),
    .rd_data (mem_rd_data)
  );

  bcsm_serial_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign out_valid          = out_valid_r;
  assign out_level          = out_level_r;
  assign out_calibrating    = out_cal_r;
  assign out_frames_done    = out_frames_r;
  assign out_point_position = 8'(out_pos_r);
  assign out_frame_end      = out_last_r;

endmodule

@@ rtl/core/bcsm_sum_mem.sv @@
module bcsm_sum_mem
  import bcsm_pkg::*;
(
  input  logic            clk,
  input  logic            wr_en,
  input  logic [PosW-1:0] wr_addr,
  input  logic [SumW-1:0] wr_data,
  input  logic            rd_en,
  input  logic [PosW-1:0] rd_addr,
  output logic [SumW-1:0] rd_data
);

  logic [SumW-1:0] mem [Points];
  logic [SumW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/core/bcsm_serial_div.sv @@
module bcsm_serial_div
  import bcsm_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  div_req_t        req,
  output logic            done,
  output logic [RawW-1:0] quot
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [StepW-1:0]  cnt_r, cnt_nxt;
  logic [RawW-1:0]   rem_r, rem_nxt;
  logic [RawW-1:0]   low_r, low_nxt;
  logic [RawW-1:0]   div_r, div_nxt;
  logic [RawW:0]     trial;
  logic              qbit;

  // One restoring step: remainder stays below the divisor.
  assign trial = {rem_r, low_r[RawW-1]};
  assign qbit  = (trial >= {1'b0, div_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    low_nxt  = low_r;
    div_nxt  = div_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = req.steps;
      rem_nxt  = req.rem;
      low_nxt  = req.low;
      div_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = qbit ? RawW'(trial - {1'b0, div_r}) : trial[RawW-1:0];
      low_nxt = {low_r[RawW-2:0], qbit};
      cnt_nxt = cnt_r - StepW'(1);
      if (cnt_r == StepW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    low_r <= low_nxt;
    div_r <= div_nxt;
  end

  assign done = done_r;
  assign quot = low_r;

endmodule

@@ verif/tb_baseline_calibrated_sample_mapper.sv @@
module tb_baseline_calibrated_sample_mapper;
  import bcsm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Item kinds and register byte addresses.
  typedef enum logic {KindSample = 1'b0, KindRestart = 1'b1} item_kind_e;
  typedef enum logic [2:0] {AddrPointCount = 3'd0, AddrDeadband = 3'd4} cfg_addr_e;

  // One row of the directed plan: a sample, a restart, or a register write.
  typedef enum logic [1:0] {RowSample, RowRestart, RowPointCount, RowDeadband} row_op_e;

  typedef struct packed {
    logic [9:0] level;
    logic       calibrating;
    logic [5:0] frames_done;
    logic [7:0] point_position;
    logic       frame_end;
  } sample_result_t;

  typedef struct packed {
    row_op_e        op;
    logic [15:0]    data;
    logic [7:0]     reps;
    logic           typed;
    sample_result_t exp;
  } plan_row_t;

  localparam int NumPlanRows    = 22;
  localparam int RandomItems    = 950;
  localparam int ModeSwapAt     = 480;   // sender busy, receiver lazy before this
  localparam int ModeQuietAt    = 880;   // no idling on either side after this
  localparam int SettleCycles   = 40;
  localparam int LongHoldCycles = 400;
  localparam int StallLimit     = 4000;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_ready;
  logic        in_kind;
  logic [15:0] in_sample;
  logic        out_valid;
  logic        out_ready;
  logic [9:0]  out_level;
  logic        out_calibrating;
  logic [5:0]  out_frames_done;
  logic [7:0]  out_point_position;
  logic        out_frame_end;

  // Mirror of the block's state and registers.
  logic [21:0] sum_per_point [Points];
  logic [15:0] baseline_per_point [Points];
  logic [5:0]  frames_seen;
  logic        calibrated;
  int unsigned next_point;
  logic [8:0]  cfg_points;
  logic [15:0] cfg_deadband;

  sample_result_t pending_results [$];
  plan_row_t      plan [NumPlanRows];

  int unsigned items_sent;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned hold_requests;
  int unsigned mismatches;

  baseline_calibrated_sample_mapper i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_kind           (in_kind),
    .in_sample         (in_sample),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_level         (out_level),
    .out_calibrating   (out_calibrating),
    .out_frames_done   (out_frames_done),
    .out_point_position(out_point_position),
    .out_frame_end     (out_frame_end)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Frame length in use: zero counts as one, anything above the store size clamps.
  function automatic int unsigned points_in_frame();
    if (cfg_points == '0) begin
      return 1;
    end else if (cfg_points > Points) begin
      return Points;
    end
    return cfg_points;
  endfunction

  function automatic logic [15:0] clamp16(input int v);
    if (v < 0) begin
      return 16'd0;
    end else if (v > 65535) begin
      return 16'hFFFF;
    end
    return 16'(v);
  endfunction

  // Drop back to calibration: frame count, flag and position all clear.
  task automatic restart_calibration();
    frames_seen = '0;
    calibrated  = 1'b0;
    next_point  = 0;
  endtask

  // Advance the mirror by one accepted item and work out what comes back.
  task automatic advance_mapper(input item_kind_e kind, input logic [15:0] raw,
                                output bit produced, output sample_result_t res);
    int unsigned n;
    int unsigned pos;
    int unsigned thr;
    int unsigned lvl;
    bit          last;
    n        = points_in_frame();
    produced = 1'b0;
    res      = '0;
    if (kind == KindRestart) begin
      restart_calibration();
    end else begin
      if (next_point >= n) begin
        next_point = 0;
      end
      pos = next_point;
      last = (pos + 1 >= n);
      lvl = 0;
      res.calibrating = !calibrated;
      if (!calibrated) begin
        // First frame overwrites the sum, later frames accumulate into it.
        if (frames_seen == '0) begin
          sum_per_point[pos] = 22'(raw);
        end else begin
          sum_per_point[pos] = sum_per_point[pos] + 22'(raw);
        end
        if (last) begin
          frames_seen = frames_seen + 6'd1;
          if (frames_seen >= CalFrames) begin
            for (int i = 0; i < n; i++) begin
              baseline_per_point[i] = 16'((32'(sum_per_point[i]) + CalHalf) / CalFrames);
            end
            calibrated = 1'b1;
          end
        end
      end else begin
        thr = baseline_per_point[pos] + cfg_deadband;
        if (thr > RawMax) begin
          thr = RawMax;
        end
        // A saturated threshold leaves no span above it: level stays zero.
        if (raw > thr && thr < RawMax) begin
          lvl = 1 + ((raw - thr) * LevelSpan) / (RawMax - thr);
          if (lvl > LevelMax) begin
            lvl = LevelMax;
          end
        end
      end
      next_point = last ? 0 : pos + 1;
      res.level          = 10'(lvl);
      res.frames_done    = frames_seen;
      res.point_position = 8'(pos);
      res.frame_end      = last;
      produced           = 1'b1;
    end
  endtask

  // Offer one item and hold it until the transfer; valid stays up afterwards so
  // back-to-back items never lower and raise it in one step.
  task automatic send_item(input item_kind_e kind, input logic [15:0] raw,
                           input bit typed, input sample_result_t typed_res);
    sample_result_t res;
    bit             produced;
    if (items_sent < ModeSwapAt) begin
      tx_idle_pct = 25;
      rx_idle_pct = 83;
    end else if (items_sent < ModeQuietAt) begin
      tx_idle_pct = 83;
      rx_idle_pct = 25;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_kind   <= kind;
    in_sample <= raw;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    advance_mapper(kind, raw, produced, res);
    if (produced) begin
      pending_results.push_back(typed ? typed_res : res);
    end
  endtask

  // Stop offering, wait for every expected result, then let a restart drain.
  task automatic settle_block();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Register write: setup cycle, then access cycle until pready.
  task automatic write_cfg(input cfg_addr_e addr, input logic [15:0] value);
    settle_block();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (addr)
      AddrPointCount: begin
        cfg_points = value[8:0];
        restart_calibration();
      end
      AddrDeadband: cfg_deadband = value;
      default: ;
    endcase
  endtask

  // Receiver: random backpressure, plus a long hold whenever one is requested.
  initial begin : receiver
    int unsigned hold_left;
    int unsigned holds_served;
    hold_left    = 0;
    holds_served = 0;
    out_ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = LongHoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
      @(posedge clk);
    end
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin : result_check
    sample_result_t got;
    sample_result_t want;
    if (out_valid && out_ready) begin
      got = {out_level, out_calibrating, out_frames_done, out_point_position, out_frame_end};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result with nothing expected: level=%0d cal=%0b frames=%0d pos=%0d end=%0b",
                   $realtime, got.level, got.calibrating, got.frames_done,
                   got.point_position, got.frame_end);
        end
      end else begin
        want = pending_results.pop_front();
        if (got.level !== want.level || got.calibrating !== want.calibrating ||
            got.frames_done !== want.frames_done ||
            got.point_position !== want.point_position ||
            got.frame_end !== want.frame_end) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: mismatch level %0d/%0d cal %0b/%0b frames %0d/%0d pos %0d/%0d end %0b/%0b",
                     $realtime, want.level, got.level, want.calibrating, got.calibrating,
                     want.frames_done, got.frames_done, want.point_position,
                     got.point_position, want.frame_end, got.frame_end);
          end
        end
      end
    end
  end

  // Watchdog: end the run once neither channel has moved for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("baseline_calibrated_sample_mapper verification failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned directed_items;
    int unsigned mapped_left;
    int unsigned spread;
    int unsigned hint_style;
    int unsigned pos;
    int unsigned thr;
    int unsigned r;
    logic [15:0] raw;
    logic [15:0] deadband_pick;
    logic [15:0] point_hint [Points];

    // Reset values of the mirror.
    cfg_points    = 9'd256;
    cfg_deadband  = 16'd50;
    restart_calibration();
    for (int i = 0; i < Points; i++) begin
      sum_per_point[i]      = '0;
      baseline_per_point[i] = '0;
    end
    items_sent    = 0;
    tx_idle_pct   = 25;
    rx_idle_pct   = 83;
    hold_requests = 0;
    mismatches    = 0;

    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_kind   <= KindSample;
    in_sample <= '0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= AddrPointCount;
    pwdata    <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed plan. Typed expectations only where the value is obvious;
    // the rest go through the mirror.
    plan = '{
      // After reset: full 256-point frame, first calibration frame.
      '{RowSample,     16'h1234, 8'd1,  1'b1, '{10'd0,    1'b1, 6'd0,  8'd0, 1'b0}},
      '{RowSample,     16'hFFFF, 8'd1,  1'b1, '{10'd0,    1'b1, 6'd0,  8'd1, 1'b0}},
      // Restart item: no result, position back to zero.
      '{RowRestart,    16'h0000, 8'd1,  1'b0, '0},
      '{RowSample,     16'h0000, 8'd1,  1'b1, '{10'd0,    1'b1, 6'd0,  8'd0, 1'b0}},
      // Point count zero acts as a single-point frame.
      '{RowPointCount, 16'd0,    8'd0,  1'b0, '0},
      '{RowSample,     16'd100,  8'd49, 1'b0, '0},
      // Completing frame: still calibrating, frame count already full.
      '{RowSample,     16'd100,  8'd1,  1'b1, '{10'd0,    1'b1, 6'd50, 8'd0, 1'b1}},
      '{RowDeadband,   16'd0,    8'd0,  1'b0, '0},
      // Baseline 100: at threshold, just above, and full scale.
      '{RowSample,     16'd100,  8'd1,  1'b1, '{10'd0,    1'b0, 6'd50, 8'd0, 1'b1}},
      '{RowSample,     16'd101,  8'd1,  1'b1, '{10'd1,    1'b0, 6'd50, 8'd0, 1'b1}},
      '{RowSample,     16'hFFFF, 8'd1,  1'b1, '{10'd1019, 1'b0, 6'd50, 8'd0, 1'b1}},
      // Deadband saturation: threshold pinned at full scale.
      '{RowDeadband,   16'hFFFF, 8'd0,  1'b0, '0},
      '{RowSample,     16'hFFFF, 8'd1,  1'b1, '{10'd0,    1'b0, 6'd50, 8'd0, 1'b1}},
      '{RowDeadband,   16'd50,   8'd0,  1'b0, '0},
      '{RowSample,     16'h8000, 8'd1,  1'b0, '0},
      // Restart while calibrated, recalibrate at full scale.
      '{RowRestart,    16'h0000, 8'd1,  1'b0, '0},
      '{RowSample,     16'hFFFF, 8'd49, 1'b0, '0},
      '{RowSample,     16'hFFFF, 8'd1,  1'b1, '{10'd0,    1'b1, 6'd50, 8'd0, 1'b1}},
      '{RowDeadband,   16'd0,    8'd0,  1'b0, '0},
      '{RowSample,     16'hFFFF, 8'd1,  1'b1, '{10'd0,    1'b0, 6'd50, 8'd0, 1'b1}},
      // Point count above the store size clamps to 256.
      '{RowPointCount, 16'd511,  8'd0,  1'b0, '0},
      '{RowSample,     16'h0000, 8'd1,  1'b1, '{10'd0,    1'b1, 6'd0,  8'd0, 1'b0}}
    };

    foreach (plan[k]) begin
      case (plan[k].op)
        RowSample: begin
          repeat (plan[k].reps) send_item(KindSample, plan[k].data, plan[k].typed, plan[k].exp);
        end
        RowRestart: send_item(KindRestart, '0, 1'b0, '0);
        RowPointCount: write_cfg(AddrPointCount, plan[k].data);
        default: write_cfg(AddrDeadband, plan[k].data);
      endcase
    end
    directed_items = items_sent;

    // Full-size frame: walk every position up to 255 and wrap into frame two.
    // Hold the receiver off meanwhile so the block fills and stalls its input.
    write_cfg(AddrPointCount, 16'd256);
    hold_requests++;
    repeat (300) send_item(KindSample, 16'($urandom), 1'b0, '0);
    send_item(KindRestart, '0, 1'b0, '0);

    // Random phases: small frames, full calibration with per-point content,
    // then mapped samples, some of them clustered around each threshold.
    while (items_sent - directed_items < RandomItems) begin
      if (!calibrated || $urandom_range(0, 99) < 60) begin
        write_cfg(AddrPointCount, 16'($urandom_range(0, 5)));
      end
      case ($urandom_range(0, 3))
        0: deadband_pick = 16'd0;
        1: deadband_pick = 16'hFFFF;
        2: deadband_pick = 16'($urandom_range(0, 400));
        default: deadband_pick = 16'($urandom);
      endcase
      write_cfg(AddrDeadband, deadband_pick);

      // Pick what each point tends to read while idle.
      spread     = $urandom_range(0, 80);
      hint_style = $urandom_range(0, 2);
      for (int i = 0; i < Points; i++) begin
        case (hint_style)
          0: point_hint[i] = 16'($urandom);
          1: point_hint[i] = 16'($urandom_range(65200, 65535));
          default: point_hint[i] = 16'($urandom_range(0, 2000));
        endcase
      end

      mapped_left = $urandom_range(20, 70);
      while (mapped_left != 0) begin
        pos = (next_point >= points_in_frame()) ? 0 : next_point;
        r   = $urandom_range(0, 99);
        if (r == 0 && calibrated) begin
          // Break the sequence now and then: back to calibration.
          send_item(KindRestart, 16'($urandom), 1'b0, '0);
        end else if (!calibrated) begin
          if (r < 4) begin
            raw = 16'($urandom);
          end else begin
            raw = clamp16(int'(point_hint[pos]) + int'($urandom_range(0, 2 * spread)) -
                          int'(spread));
          end
          send_item(KindSample, raw, 1'b0, '0);
        end else begin
          thr = baseline_per_point[pos] + cfg_deadband;
          if (thr > RawMax) begin
            thr = RawMax;
          end
          if (r < 35) begin
            raw = clamp16(int'(thr) + int'($urandom_range(0, 8)) - 4);
          end else if (r < 70) begin
            raw = 16'($urandom);
          end else if (r < 78) begin
            raw = 16'hFFFF;
          end else if (r < 85) begin
            raw = 16'h0000;
          end else begin
            raw = 16'(thr + $urandom_range(0, RawMax - thr));
          end
          send_item(KindSample, raw, 1'b0, '0);
          mapped_left--;
        end
      end
    end

    // Drain and give the verdict.
    settle_block();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("baseline_calibrated_sample_mapper verification clean");
    end else begin
      $display("baseline_calibrated_sample_mapper verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/bcsm_pkg.sv
rtl/core/bcsm_sum_mem.sv
rtl/core/bcsm_serial_div.sv
rtl/core/baseline_calibrated_sample_mapper.sv
verif/tb_baseline_calibrated_sample_mapper.sv
